### design/stsq_pkg.sv
`timescale 1ns / 1ps
// Package: shared constants, types and helpers of the servo teach/replay sequencer.
package stsq_pkg;

  localparam int JOINTS = 5;
  localparam int ANGLE_W = 8;
  localparam int POSE_W = JOINTS * ANGLE_W;
  localparam int DEFAULT_MAX_POSES = 16;
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] POSITIONS_RESET = 5'd5;
  localparam int INDEX_OUT_W = 4;

  typedef enum logic [3:0] {
    MODE_MANUAL = 4'b0001,
    MODE_MENU   = 4'b0010,
    MODE_RECORD = 4'b0100,
    MODE_REPLAY = 4'b1000
  } mode_t;

  localparam logic [1:0] MODE_CODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_CODE_MENU   = 2'd1;
  localparam logic [1:0] MODE_CODE_RECORD = 2'd2;
  localparam logic [1:0] MODE_CODE_REPLAY = 2'd3;

  localparam logic [1:0] CHOICE_MANUAL = 2'd0;
  localparam logic [1:0] CHOICE_RECORD = 2'd1;
  localparam logic [1:0] CHOICE_REPLAY = 2'd2;

  typedef struct packed {
    logic               up_level;
    logic               down_level;
    logic               ok_level;
    logic [ANGLE_W-1:0] pot_angle_1;
    logic [ANGLE_W-1:0] pot_angle_2;
    logic [ANGLE_W-1:0] pot_angle_3;
    logic [ANGLE_W-1:0] pot_angle_4;
    logic [ANGLE_W-1:0] pot_angle_5;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]     servo_angle_1;
    logic [ANGLE_W-1:0]     servo_angle_2;
    logic [ANGLE_W-1:0]     servo_angle_3;
    logic [ANGLE_W-1:0]     servo_angle_4;
    logic [ANGLE_W-1:0]     servo_angle_5;
    logic                   drive_servos;
    logic [1:0]             mode_now;
    logic [1:0]             menu_choice;
    logic [INDEX_OUT_W-1:0] pose_index;
    logic                   pose_saved;
  } out_item_t;

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] c;
    case (m)
      MODE_MANUAL: c = MODE_CODE_MANUAL;
      MODE_MENU:   c = MODE_CODE_MENU;
      MODE_RECORD: c = MODE_CODE_RECORD;
      MODE_REPLAY: c = MODE_CODE_REPLAY;
      default:     c = MODE_CODE_MENU;
    endcase
    return c;
  endfunction

endpackage

### design/stsq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input and result transactions.
interface stsq_in_if;
  logic                valid;
  logic                ready;
  stsq_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface stsq_out_if;
  logic                valid;
  logic                ready;
  stsq_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/stsq_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module stsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/servo_teach_replay_sequencer.sv
`timescale 1ns / 1ps
// Servo teach/replay sequencer top level: mode control and pose store.
// A result is presented in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless the sink stalls; the pose RAM read issues
// at accept and its registered data feeds the result stage, which holds while the sink stalls.
// Reset (rst, synchronous): menu mode with the manual entry highlighted, pose index and
// button history cleared, default pose count, pose valid bits cleared so unwritten poses
// read as zero.
module servo_teach_replay_sequencer #(
  parameter int MAX_POSES = stsq_pkg::DEFAULT_MAX_POSES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [stsq_pkg::CFG_W-1:0] cfg_wdata,
  stsq_in_if.sink                    in_ch,
  stsq_out_if.source                 out_ch
);

  localparam int IW = $clog2(MAX_POSES);
  localparam int CW = ($clog2(MAX_POSES + 1) > stsq_pkg::CFG_W) ?
                      $clog2(MAX_POSES + 1) : stsq_pkg::CFG_W;
  localparam int AW = stsq_pkg::ANGLE_W;
  localparam int PW = stsq_pkg::POSE_W;

  logic [stsq_pkg::CFG_W-1:0] positions_in_use;
  stsq_pkg::mode_t            mode, mode_next;
  logic [1:0]                 choice, choice_next;
  logic [IW-1:0]              index, index_next;
  logic                       up_prev, up_prev_next;
  logic                       down_prev, down_prev_next;
  logic                       ok_prev, ok_prev_next;
  logic [MAX_POSES-1:0]       pose_valid;

  logic                       s1_valid;
  logic [PW-1:0]              s1_pots;
  logic                       s1_use_ram;
  logic                       s1_entry_valid;
  logic                       s1_drive;
  logic [1:0]                 s1_mode;
  logic [1:0]                 s1_choice;
  logic [stsq_pkg::INDEX_OUT_W-1:0] s1_index;
  logic                       s1_saved;

  logic                       accept;
  logic [PW-1:0]              pots;
  logic [PW-1:0]              pots_out;
  logic [PW-1:0]              ram_rdata;
  logic [PW-1:0]              angles;
  logic [CW-1:0]              cfg_ext;
  logic [CW-1:0]              count;
  logic [CW-1:0]              index_inc;
  logic                       at_last;
  logic                       up_hit, down_hit, ok_hit;
  logic                       use_ram, drive, saved, wr_en;
  logic [IW+stsq_pkg::INDEX_OUT_W-1:0] index_ext;

  assign in_ch.ready = !s1_valid || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  assign pots = {in_ch.payload.pot_angle_5, in_ch.payload.pot_angle_4,
                 in_ch.payload.pot_angle_3, in_ch.payload.pot_angle_2,
                 in_ch.payload.pot_angle_1};

  assign cfg_ext = CW'(positions_in_use);
  always_comb begin
    if (cfg_ext == '0) begin
      count = CW'(1);
    end else if (cfg_ext > CW'(MAX_POSES)) begin
      count = CW'(MAX_POSES);
    end else begin
      count = cfg_ext;
    end
  end

  assign index_inc = CW'(index) + CW'(1);
  assign at_last = index_inc >= count;
  assign up_hit = in_ch.payload.up_level && !up_prev;
  assign down_hit = in_ch.payload.down_level && !down_prev;
  assign ok_hit = in_ch.payload.ok_level && !ok_prev;
  assign index_ext = {{stsq_pkg::INDEX_OUT_W{1'b0}}, index};

  always_comb begin
    logic [1:0] ch;
    mode_next = mode;
    ch = choice;
    index_next = index;
    up_prev_next = up_prev;
    down_prev_next = down_prev;
    ok_prev_next = in_ch.payload.ok_level;
    pots_out = pots;
    use_ram = 1'b0;
    drive = 1'b1;
    saved = 1'b0;
    wr_en = 1'b0;
    case (mode)
      stsq_pkg::MODE_MANUAL: begin
        if (ok_hit) mode_next = stsq_pkg::MODE_MENU;
      end
      stsq_pkg::MODE_MENU: begin
        pots_out = '0;
        drive = 1'b0;
        up_prev_next = in_ch.payload.up_level;
        down_prev_next = in_ch.payload.down_level;
        if (up_hit) ch = (ch == stsq_pkg::CHOICE_MANUAL) ? stsq_pkg::CHOICE_REPLAY : ch - 2'd1;
        if (down_hit) ch = (ch >= stsq_pkg::CHOICE_REPLAY) ? stsq_pkg::CHOICE_MANUAL : ch + 2'd1;
        if (ok_hit) begin
          case (ch)
            stsq_pkg::CHOICE_MANUAL: mode_next = stsq_pkg::MODE_MANUAL;
            stsq_pkg::CHOICE_RECORD: mode_next = stsq_pkg::MODE_RECORD;
            stsq_pkg::CHOICE_REPLAY: mode_next = stsq_pkg::MODE_REPLAY;
            default:                 mode_next = stsq_pkg::MODE_MENU;
          endcase
        end
      end
      stsq_pkg::MODE_RECORD: begin
        if (ok_hit) begin
          wr_en = 1'b1;
          saved = 1'b1;
          if (at_last) begin
            index_next = '0;
            mode_next = stsq_pkg::MODE_MENU;
          end else begin
            index_next = IW'(index_inc);
          end
        end
      end
      stsq_pkg::MODE_REPLAY: begin
        use_ram = 1'b1;
        index_next = at_last ? '0 : IW'(index_inc);
        if (ok_hit) begin
          index_next = '0;
          mode_next = stsq_pkg::MODE_MENU;
        end
      end
      default: begin
        mode_next = stsq_pkg::MODE_MENU;
        drive = 1'b0;
      end
    endcase
    choice_next = ch;
  end

  stsq_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_POSES)
  ) u_pose_ram (
    .clk  (clk),
    .we   (accept && wr_en),
    .waddr(index),
    .wdata(pots),
    .re   (accept && use_ram),
    .raddr(index),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      positions_in_use <= stsq_pkg::POSITIONS_RESET;
      mode <= stsq_pkg::MODE_MENU;
      choice <= stsq_pkg::CHOICE_MANUAL;
      index <= '0;
      up_prev <= 1'b0;
      down_prev <= 1'b0;
      ok_prev <= 1'b0;
      pose_valid <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (cfg_we) positions_in_use <= cfg_wdata;
      if (accept) begin
        mode <= mode_next;
        choice <= choice_next;
        index <= index_next;
        up_prev <= up_prev_next;
        down_prev <= down_prev_next;
        ok_prev <= ok_prev_next;
        if (wr_en) pose_valid[index] <= 1'b1;
        s1_valid <= 1'b1;
      end else if (out_ch.ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pots <= pots_out;
      s1_use_ram <= use_ram;
      s1_entry_valid <= pose_valid[index];
      s1_drive <= drive;
      s1_mode <= stsq_pkg::mode_code(mode_next);
      s1_choice <= choice_next;
      s1_index <= index_ext[stsq_pkg::INDEX_OUT_W-1:0];
      s1_saved <= saved;
    end
  end

  always_comb begin
    if (s1_use_ram) begin
      angles = s1_entry_valid ? ram_rdata : '0;
    end else begin
      angles = s1_pots;
    end
  end

  assign out_ch.valid = s1_valid;
  assign out_ch.payload.servo_angle_1 = angles[0*AW +: AW];
  assign out_ch.payload.servo_angle_2 = angles[1*AW +: AW];
  assign out_ch.payload.servo_angle_3 = angles[2*AW +: AW];
  assign out_ch.payload.servo_angle_4 = angles[3*AW +: AW];
  assign out_ch.payload.servo_angle_5 = angles[4*AW +: AW];
  assign out_ch.payload.drive_servos = s1_drive;
  assign out_ch.payload.mode_now = s1_mode;
  assign out_ch.payload.menu_choice = s1_choice;
  assign out_ch.payload.pose_index = s1_index;
  assign out_ch.payload.pose_saved = s1_saved;

endmodule
